FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Types and constants of the partial shuffle draw unit.
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int POOL_SIZE_DEFAULT = 42;
   localparam int CNT_W             = 6;
   localparam int RND_W             = 31;

   localparam logic [CNT_W-1:0] DRAW_COUNT_RESET = 6'd7;

   localparam logic ACT_NEXT  = 1'b0;
   localparam logic ACT_START = 1'b1;

   typedef struct packed {
      logic             action;
      logic [RND_W-1:0] random_word;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] number;
      logic [CNT_W-1:0] draw_position;
      logic             last;
      logic             error;
   } rsp_type;

endpackage

FILE: hw/rtl/partial_shuffle_draw_unit.sv
// ----------------------------------------------------------------------------
// partial_shuffle_draw_unit
// Draws numbers 1..POOL_SIZE without replacement by a partial Fisher-Yates
// shuffle held in a pool RAM with per-entry written marks.
// ----------------------------------------------------------------------------
//   channel | ports                          | direction
//   request | req_valid req_stall req_data   | in
//   result  | rsp_valid rsp_stall rsp_data   | out
//   csr     | csr_valid csr_ready csr_data   | in (draw_count)
//
// A draw result passes the bit-serial modulo unit, one handoff, two RAM
// reads, two RAM writes and one result load. An error result goes to ST_DONE
// and is loaded from there into the result register. One request is in
// flight at a time; the next is taken the cycle after the result is loaded.
// Reset is synchronous; it clears the written marks at once, no clearing pass.
// rsp_stall only delays the return to idle while a result waits.
// ----------------------------------------------------------------------------
module partial_shuffle_draw_unit #(
   parameter int POOL_SIZE = psd_pkg::POOL_SIZE_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  psd_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output psd_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [psd_pkg::CNT_W-1:0]  csr_data
);

   localparam int CNT_W    = psd_pkg::CNT_W;
   localparam int IDX_W    = $clog2(POOL_SIZE);
   localparam int VAL_W    = $clog2(POOL_SIZE + 1);
   localparam int CNT_MAX  = 2**CNT_W - 1;
   localparam int POOL_CAP = (POOL_SIZE > CNT_MAX) ? CNT_MAX : POOL_SIZE;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_RD_I,
      ST_RD_J,
      ST_WR_I,
      ST_WR_J,
      ST_DONE
   } state_type;

   state_type            state_ff;
   logic                 open_ff;
   logic [CNT_W-1:0]     draws_ff;
   logic [CNT_W-1:0]     draw_count_ff;
   logic [POOL_SIZE-1:0] written_ff;
   logic [CNT_W-1:0]     i_ff;
   logic [IDX_W-1:0]     j_ff;
   logic [VAL_W-1:0]     vi_ff;
   psd_pkg::rsp_type     res_ff;
   logic                 rsp_valid_ff;
   psd_pkg::rsp_type     rsp_data_ff;

   logic [CNT_W-1:0] limit;
   logic             open_eff;
   logic [CNT_W-1:0] draws_eff;
   logic [CNT_W-1:0] draws_next;
   logic             draw_err;
   logic [IDX_W-1:0] i_idx;
   logic [VAL_W-1:0] vj;
   logic             mod_start;
   logic             mod_done;
   logic [VAL_W-1:0] mod_rem;
   logic             rsp_load;
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [VAL_W-1:0] ram_wr_data;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [VAL_W-1:0] ram_rd_data;

   always_comb begin
      limit      = (draw_count_ff > CNT_W'(POOL_CAP)) ? CNT_W'(POOL_CAP) : draw_count_ff;
      open_eff   = (req_data.action == psd_pkg::ACT_START) || open_ff;
      draws_eff  = (req_data.action == psd_pkg::ACT_START) ? '0 : draws_ff;
      draws_next = draws_eff + CNT_W'(1);
      draw_err   = !open_eff || (draws_eff >= limit);
      i_idx      = IDX_W'(i_ff);
      vj         = written_ff[j_ff] ? ram_rd_data : VAL_W'(j_ff) + VAL_W'(1);
   end

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign mod_start = (state_ff == ST_IDLE) && req_valid && !reset && !draw_err;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign ram_wr_en   = (state_ff == ST_WR_I) || (state_ff == ST_WR_J);
   assign ram_wr_addr = (state_ff == ST_WR_I) ? i_idx : j_ff;
   assign ram_wr_data = (state_ff == ST_WR_I) ? vj : vi_ff;
   assign ram_rd_addr = (state_ff == ST_RD_I) ? i_idx : j_ff;

   psd_mod_unit #(
      .DIV_W (VAL_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_data.random_word),
      .divisor   (VAL_W'(POOL_SIZE) - VAL_W'(draws_eff)),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   psd_ram #(
      .WIDTH (VAL_W),
      .DEPTH (POOL_SIZE)
   ) u_pool (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         open_ff       <= 1'b0;
         draws_ff      <= '0;
         draw_count_ff <= psd_pkg::DRAW_COUNT_RESET;
         written_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            draw_count_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= res_ff;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  if (req_data.action == psd_pkg::ACT_START) begin
                     written_ff <= '0;
                  end
                  i_ff <= draws_eff;
                  if (draw_err) begin
                     open_ff              <= 1'b0;
                     draws_ff             <= draws_eff;
                     res_ff.number        <= '0;
                     res_ff.draw_position <= '0;
                     res_ff.last          <= 1'b0;
                     res_ff.error         <= 1'b1;
                     state_ff             <= ST_DONE;
                  end else begin
                     open_ff              <= draws_next < limit;
                     draws_ff             <= draws_next;
                     res_ff.draw_position <= draws_eff;
                     res_ff.last          <= draws_next == limit;
                     res_ff.error         <= 1'b0;
                     state_ff             <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               if (mod_done) begin
                  j_ff     <= i_idx + IDX_W'(mod_rem);
                  state_ff <= ST_RD_I;
               end
            end
            ST_RD_I: begin
               state_ff <= ST_RD_J;
            end
            ST_RD_J: begin
               vi_ff    <= written_ff[i_idx] ? ram_rd_data : VAL_W'(i_idx) + VAL_W'(1);
               state_ff <= ST_WR_I;
            end
            ST_WR_I: begin
               res_ff.number     <= CNT_W'(vj);
               written_ff[i_idx] <= 1'b1;
               state_ff          <= ST_WR_J;
            end
            ST_WR_J: begin
               written_ff[j_ff] <= 1'b1;
               state_ff         <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hw/rtl/psd_ram.sv
// ----------------------------------------------------------------------------
// psd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psd_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/psd_mod_unit.sv
// ----------------------------------------------------------------------------
// psd_mod_unit
// Bit-serial restoring remainder: dividend mod divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module psd_mod_unit #(
   parameter int DIV_W = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [psd_pkg::RND_W-1:0]  dividend,
   input  logic [DIV_W-1:0]           divisor,
   output logic                       done,
   output logic [DIV_W-1:0]           remainder
);

   localparam int STEP_W = $clog2(psd_pkg::RND_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(psd_pkg::RND_W - 1);

   logic [psd_pkg::RND_W-1:0] shift_ff, shift_in;
   logic [DIV_W-1:0]          rem_ff, rem_in;
   logic [DIV_W-1:0]          div_ff, div_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [DIV_W:0]            trial;
   logic [DIV_W:0]            diff;

   always_comb begin
      trial    = {rem_ff, shift_ff[psd_pkg::RND_W-1]};
      diff     = trial - {1'b0, div_ff};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
         step_in  = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[psd_pkg::RND_W-2:0], 1'b0};
         rem_in   = (trial >= {1'b0, div_ff}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         step_in  = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: hw/rtl/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks of the partial shuffle draw unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input psd_pkg::req_type           req_data,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input psd_pkg::rsp_type           rsp_data
);

   logic req_accept;

   assign req_accept = req_valid && !req_stall;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result changed while stalled")

   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_accept, req_stall, "request accepted while a draw is in flight")

   `ASSERT_IMPLIES(a_err_zero, clock, reset, rsp_valid && rsp_data.error, (rsp_data.number == '0) && (rsp_data.draw_position == '0) && !rsp_data.last, "error result carries data")

   `ASSERT_IMPLIES(a_last_ok, clock, reset, rsp_valid && rsp_data.last, !rsp_data.error, "last marked on an error result")

endmodule

bind partial_shuffle_draw_unit psd_checker u_psd_checker (.*);
